// ===== hw/rtl/rtn_pkg.sv =====
package rtn_pkg;

  localparam int MUL_XW   = 36;
  localparam int MUL_YW   = 19;
  localparam int PROD_W   = MUL_XW + MUL_YW;
  localparam int ACC_W    = 74;
  localparam int QW       = 56;
  localparam int T_W      = 32;
  localparam int DIST_W   = 36;
  localparam int HI_SHIFT = 18;
  localparam int CNT_W    = 16;

  typedef logic signed [15:0]       coord_t;
  typedef logic signed [16:0]       diff_t;
  typedef logic signed [MUL_XW-1:0] mulx_t;
  typedef logic signed [MUL_YW-1:0] muly_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [QW-1:0]     quo_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
    logic   last_triangle;
  } rtn_in_t;

  typedef struct packed {
    coord_t             hit_x;
    coord_t             hit_y;
    coord_t             hit_z;
    logic [CNT_W-1:0]   hit_count;
  } rtn_out_t;

  typedef struct packed {
    coord_t [2:0] a;
    coord_t [2:0] b;
    coord_t [2:0] c;
    diff_t  [2:0] e1;
    diff_t  [2:0] e2;
    diff_t  [2:0] aq;
    logic         last;
  } rtn_item_t;

  typedef enum logic [3:0] {
    DST_N0,
    DST_N1,
    DST_N2,
    DST_NUM,
    DST_DEN,
    DST_P0,
    DST_P1,
    DST_P2,
    DST_X0,
    DST_X1,
    DST_X2,
    DST_SIGN,
    DST_DIST
  } dst_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
    logic neg;
    logic hi;
    dst_t dst;
  } mac_ctrl_t;

  typedef struct packed {
    logic en;
    dst_t dst;
    acc_t acc;
  } mac_res_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_NORM,
    BK_ABS,
    BK_RANGE,
    BK_DIV,
    BK_POINT,
    BK_EDGE,
    BK_DIST,
    BK_UPDATE,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_ORIGIN_Z,
    CFG_DIR_X,
    CFG_DIR_Y,
    CFG_DIR_Z
  } cfg_idx_t;

  localparam coord_t DIR_Z_RESET = 16'sd256;

endpackage

// ===== hw/rtl/ray_triangle_nearest_hit_core.sv =====
// Nearest ray/triangle hit over a streamed mesh.
// Ray origin and direction (signed Q8.8) are held in six registers written
// over the cfg_ port (always ready); write them only while the core is idle.
// Triangles enter as in_word on in_valid/in_stall into a two-word queue.
// A back end works through one triangle at a time on a single shared 36x19
// multiply-accumulate unit plus a 32-step restoring divider for the plane
// crossing; a triangle rejected early (parallel, behind origin or too far)
// skips the divider and the edge tests.
// The queue can take new triangles while the back end is busy with one.
// A triangle flagged last_triangle produces one out_word on
// out_valid/out_stall (nearest hit point, zero if none, and hit count) from
// the emit state once the output slot is free; the state is then cleared.
// While out_stall holds a word, the back end keeps working on the next
// triangle and waits only when it has another result to present.
// Reset (rst_n low, synchronous) empties the queue, drops any pending word,
// clears the hit state and sets the ray to origin 0, direction (0, 0, 1.0).
module ray_triangle_nearest_hit_core #(
  parameter logic [31:0] MAX_HITS = 32'd65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rtn_pkg::rtn_in_t   in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output rtn_pkg::rtn_out_t  out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  rtn_pkg::coord_t [2:0] org_r;
  rtn_pkg::coord_t [2:0] dir_r;
  logic                  q_valid;
  logic                  q_pop;
  rtn_pkg::rtn_item_t    q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r <= '0;
      dir_r <= {rtn_pkg::DIR_Z_RESET, 16'sd0, 16'sd0};
    end else if (cfg_valid && cfg_ready) begin
      case (rtn_pkg::cfg_idx_t'(cfg_index))
        rtn_pkg::CFG_ORIGIN_X: org_r[0] <= cfg_data;
        rtn_pkg::CFG_ORIGIN_Y: org_r[1] <= cfg_data;
        rtn_pkg::CFG_ORIGIN_Z: org_r[2] <= cfg_data;
        rtn_pkg::CFG_DIR_X:    dir_r[0] <= cfg_data;
        rtn_pkg::CFG_DIR_Y:    dir_r[1] <= cfg_data;
        rtn_pkg::CFG_DIR_Z:    dir_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  rtn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .org      (org_r),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  rtn_back #(
    .MAX_HITS (MAX_HITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .org       (org_r),
    .dir       (dir_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== hw/rtl/rtn_front.sv =====
module rtn_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  rtn_pkg::rtn_in_t           in_word,
  input  rtn_pkg::coord_t [2:0]      org,
  output logic                       q_valid,
  input  logic                       q_pop,
  output rtn_pkg::rtn_item_t         q_item
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  rtn_pkg::rtn_item_t item_in;
  rtn_pkg::rtn_item_t mem_r [DEPTH];
  logic [PW-1:0]      wptr_r;
  logic [PW-1:0]      rptr_r;
  logic [CW-1:0]      cnt_r;
  logic               wr;

  always_comb begin
    item_in.a[0] = in_word.a_x;
    item_in.a[1] = in_word.a_y;
    item_in.a[2] = in_word.a_z;
    item_in.b[0] = in_word.b_x;
    item_in.b[1] = in_word.b_y;
    item_in.b[2] = in_word.b_z;
    item_in.c[0] = in_word.c_x;
    item_in.c[1] = in_word.c_y;
    item_in.c[2] = in_word.c_z;
    item_in.last = in_word.last_triangle;
    for (int i = 0; i < 3; i++) begin
      item_in.e1[i] = rtn_pkg::diff_t'($signed(item_in.b[i]))
                    - rtn_pkg::diff_t'($signed(item_in.a[i]));
      item_in.e2[i] = rtn_pkg::diff_t'($signed(item_in.c[i]))
                    - rtn_pkg::diff_t'($signed(item_in.a[i]));
      item_in.aq[i] = rtn_pkg::diff_t'($signed(item_in.a[i]))
                    - rtn_pkg::diff_t'($signed(org[i]));
    end
  end

  assign in_stall = (cnt_r == CW'(DEPTH));
  assign wr       = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr) begin
        wptr_r <= wptr_r + PW'(1);
      end
      if (q_pop) begin
        rptr_r <= rptr_r + PW'(1);
      end
      if (wr && !q_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!wr && q_pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/rtn_mac.sv =====
module rtn_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  rtn_pkg::mac_ctrl_t  ctrl,
  input  rtn_pkg::mulx_t      op_x,
  input  rtn_pkg::muly_t      op_y,
  output rtn_pkg::mac_res_t   res
);

  rtn_pkg::prod_t     prod_r;
  rtn_pkg::mac_ctrl_t ctrl_r;
  rtn_pkg::acc_t      acc_r;
  rtn_pkg::acc_t      acc_nxt;
  rtn_pkg::acc_t      base;
  rtn_pkg::acc_t      term;

  always_comb begin
    base    = ctrl_r.first ? '0 : acc_r;
    term    = rtn_pkg::acc_t'(prod_r) <<< (ctrl_r.hi ? rtn_pkg::HI_SHIFT : 0);
    acc_nxt = ctrl_r.neg ? (base - term) : (base + term);
  end

  assign res.en  = ctrl_r.issue && ctrl_r.last;
  assign res.dst = ctrl_r.dst;
  assign res.acc = acc_nxt;

  always_ff @(posedge clk) begin
    prod_r <= rtn_pkg::prod_t'(op_x * op_y);
    if (ctrl_r.issue) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl;
    end
  end

endmodule

// ===== hw/rtl/rtn_back.sv =====
module rtn_back #(
  parameter logic [31:0] MAX_HITS = 32'd65535
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rtn_pkg::coord_t [2:0]  org,
  input  rtn_pkg::coord_t [2:0]  dir,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  rtn_pkg::rtn_item_t     q_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rtn_pkg::rtn_out_t      out_word
);

  localparam logic [rtn_pkg::CNT_W-1:0] CNT_LIMIT =
    (MAX_HITS < 32'd65535) ? MAX_HITS[rtn_pkg::CNT_W-1:0] : '1;

  rtn_pkg::bk_state_t state_r, state_nxt;
  logic [4:0]         step_r, step_nxt;
  logic [1:0]         edge_r, edge_nxt;

  rtn_pkg::mac_ctrl_t mc;
  rtn_pkg::mulx_t     mx;
  rtn_pkg::muly_t     my;
  rtn_pkg::mac_res_t  res;

  rtn_pkg::rtn_item_t it_r;
  rtn_pkg::mulx_t     n_r  [3];
  rtn_pkg::mulx_t     xc_r [3];
  rtn_pkg::quo_t      num_r, den_r;
  logic [rtn_pkg::QW-1:0]  un_r, ud_r;
  logic [rtn_pkg::QW-1:0]  rem_r;
  logic [rtn_pkg::T_W-1:0] dvd_r, t_r;
  logic               sign_bad_r;
  rtn_pkg::coord_t    p_r [3];
  rtn_pkg::diff_t     d_r [3];
  rtn_pkg::diff_t     u_r [3];
  rtn_pkg::diff_t     w_r [3];
  logic               cand_r, oor_r, any_pos_r, any_neg_r;
  logic [rtn_pkg::DIST_W-1:0] dist_r;

  logic [rtn_pkg::CNT_W-1:0]  hits_r;
  logic [rtn_pkg::DIST_W-1:0] best_r;
  rtn_pkg::coord_t            bp_r [3];
  logic                       out_valid_r;
  rtn_pkg::rtn_out_t          out_word_r;

  rtn_pkg::coord_t [2:0] sv, ev;
  logic [rtn_pkg::QW:0]  rem_sh;
  logic                  ge;
  logic [1:0]            pidx;
  logic signed [32:0]    psum;
  logic                  oor;
  logic                  hit;
  logic                  slot_free;
  logic                  reject;

  rtn_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mc),
    .op_x  (mx),
    .op_y  (my),
    .res   (res)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign slot_free = !out_valid_r || !out_stall;
  assign hit       = cand_r && !(any_pos_r && any_neg_r);
  assign reject    = sign_bad_r || ((un_r >> 16) >= ud_r);

  always_comb begin
    case (edge_r)
      2'd0:    begin sv = it_r.a; ev = it_r.b; end
      2'd1:    begin sv = it_r.b; ev = it_r.c; end
      default: begin sv = it_r.c; ev = it_r.a; end
    endcase
    rem_sh = {rem_r, dvd_r[rtn_pkg::T_W-1]};
    ge     = (rem_sh >= {1'b0, ud_r});
    case (res.dst)
      rtn_pkg::DST_P1: pidx = 2'd1;
      rtn_pkg::DST_P2: pidx = 2'd2;
      default:         pidx = 2'd0;
    endcase
    psum = 33'($signed(org[pidx])) + 33'($signed(res.acc[47:16]));
    oor  = !((&psum[32:15]) || !(|psum[32:15]));
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + 5'd1;
    edge_nxt  = edge_r;
    q_pop     = 1'b0;
    mc        = '0;
    mx        = '0;
    my        = '0;
    case (state_r)
      rtn_pkg::BK_IDLE: begin
        step_nxt = '0;
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = rtn_pkg::BK_NORM;
        end
      end
      rtn_pkg::BK_NORM: begin
        case (step_r)
          5'd0: begin
            mx = rtn_pkg::mulx_t'($signed(it_r.e1[1]));
            my = rtn_pkg::muly_t'($signed(it_r.e2[2]));
            mc.issue = 1'b1; mc.first = 1'b1;
          end
          5'd1: begin
            mx = rtn_pkg::mulx_t'($signed(it_r.e1[2]));
            my = rtn_pkg::muly_t'($signed(it_r.e2[1]));
            mc.issue = 1'b1; mc.neg = 1'b1; mc.last = 1'b1; mc.dst = rtn_pkg::DST_N0;
          end
          5'd2: begin
            mx = rtn_pkg::mulx_t'($signed(it_r.e1[2]));
            my = rtn_pkg::muly_t'($signed(it_r.e2[0]));
            mc.issue = 1'b1; mc.first = 1'b1;
          end
          5'd3: begin
            mx = rtn_pkg::mulx_t'($signed(it_r.e1[0]));
            my = rtn_pkg::muly_t'($signed(it_r.e2[2]));
            mc.issue = 1'b1; mc.neg = 1'b1; mc.last = 1'b1; mc.dst = rtn_pkg::DST_N1;
          end
          5'd4: begin
            mx = rtn_pkg::mulx_t'($signed(it_r.e1[0]));
            my = rtn_pkg::muly_t'($signed(it_r.e2[1]));
            mc.issue = 1'b1; mc.first = 1'b1;
          end
          5'd5: begin
            mx = rtn_pkg::mulx_t'($signed(it_r.e1[1]));
            my = rtn_pkg::muly_t'($signed(it_r.e2[0]));
            mc.issue = 1'b1; mc.neg = 1'b1; mc.last = 1'b1; mc.dst = rtn_pkg::DST_N2;
          end
          5'd7: begin
            mx = n_r[0];
            my = rtn_pkg::muly_t'($signed(it_r.aq[0]));
            mc.issue = 1'b1; mc.first = 1'b1;
          end
          5'd8: begin
            mx = n_r[1];
            my = rtn_pkg::muly_t'($signed(it_r.aq[1]));
            mc.issue = 1'b1;
          end
          5'd9: begin
            mx = n_r[2];
            my = rtn_pkg::muly_t'($signed(it_r.aq[2]));
            mc.issue = 1'b1; mc.last = 1'b1; mc.dst = rtn_pkg::DST_NUM;
          end
          5'd10: begin
            mx = n_r[0];
            my = rtn_pkg::muly_t'($signed(dir[0]));
            mc.issue = 1'b1; mc.first = 1'b1;
          end
          5'd11: begin
            mx = n_r[1];
            my = rtn_pkg::muly_t'($signed(dir[1]));
            mc.issue = 1'b1;
          end
          5'd12: begin
            mx = n_r[2];
            my = rtn_pkg::muly_t'($signed(dir[2]));
            mc.issue = 1'b1; mc.last = 1'b1; mc.dst = rtn_pkg::DST_DEN;
          end
          5'd13: begin
            state_nxt = rtn_pkg::BK_ABS;
            step_nxt  = '0;
          end
          default: ;
        endcase
      end
      rtn_pkg::BK_ABS: begin
        state_nxt = rtn_pkg::BK_RANGE;
        step_nxt  = '0;
      end
      rtn_pkg::BK_RANGE: begin
        step_nxt  = '0;
        state_nxt = reject ? rtn_pkg::BK_UPDATE : rtn_pkg::BK_DIV;
      end
      rtn_pkg::BK_DIV: begin
        if (step_r == 5'd31) begin
          state_nxt = rtn_pkg::BK_POINT;
          step_nxt  = '0;
        end
      end
      rtn_pkg::BK_POINT: begin
        case (step_r)
          5'd0, 5'd1, 5'd2: begin
            mx = rtn_pkg::mulx_t'({4'b0, t_r});
            my = rtn_pkg::muly_t'($signed(dir[step_r[1:0]]));
            mc.issue = 1'b1; mc.first = 1'b1; mc.last = 1'b1;
            case (step_r[1:0])
              2'd0:    mc.dst = rtn_pkg::DST_P0;
              2'd1:    mc.dst = rtn_pkg::DST_P1;
              default: mc.dst = rtn_pkg::DST_P2;
            endcase
          end
          5'd4: begin
            step_nxt  = '0;
            edge_nxt  = '0;
            state_nxt = oor_r ? rtn_pkg::BK_UPDATE : rtn_pkg::BK_EDGE;
          end
          default: ;
        endcase
      end
      rtn_pkg::BK_EDGE: begin
        case (step_r)
          5'd1: begin
            mx = rtn_pkg::mulx_t'($signed(u_r[1]));
            my = rtn_pkg::muly_t'($signed(w_r[2]));
            mc.issue = 1'b1; mc.first = 1'b1;
          end
          5'd2: begin
            mx = rtn_pkg::mulx_t'($signed(u_r[2]));
            my = rtn_pkg::muly_t'($signed(w_r[1]));
            mc.issue = 1'b1; mc.neg = 1'b1; mc.last = 1'b1; mc.dst = rtn_pkg::DST_X0;
          end
          5'd3: begin
            mx = rtn_pkg::mulx_t'($signed(u_r[2]));
            my = rtn_pkg::muly_t'($signed(w_r[0]));
            mc.issue = 1'b1; mc.first = 1'b1;
          end
          5'd4: begin
            mx = rtn_pkg::mulx_t'($signed(u_r[0]));
            my = rtn_pkg::muly_t'($signed(w_r[2]));
            mc.issue = 1'b1; mc.neg = 1'b1; mc.last = 1'b1; mc.dst = rtn_pkg::DST_X1;
          end
          5'd5: begin
            mx = rtn_pkg::mulx_t'($signed(u_r[0]));
            my = rtn_pkg::muly_t'($signed(w_r[1]));
            mc.issue = 1'b1; mc.first = 1'b1;
          end
          5'd6: begin
            mx = rtn_pkg::mulx_t'($signed(u_r[1]));
            my = rtn_pkg::muly_t'($signed(w_r[0]));
            mc.issue = 1'b1; mc.neg = 1'b1; mc.last = 1'b1; mc.dst = rtn_pkg::DST_X2;
          end
          5'd8, 5'd10, 5'd12: begin
            mx = xc_r[step_r[2:1]];
            my = rtn_pkg::muly_t'($signed(n_r[step_r[2:1]][35:18]));
            mc.issue = 1'b1; mc.hi = 1'b1; mc.first = (step_r == 5'd8);
          end
          5'd9, 5'd11, 5'd13: begin
            mx = xc_r[step_r[2:1]];
            my = rtn_pkg::muly_t'({1'b0, n_r[step_r[2:1]][17:0]});
            mc.issue = 1'b1;
            mc.last  = (step_r == 5'd13);
            mc.dst   = rtn_pkg::DST_SIGN;
          end
          5'd14: begin
            step_nxt = '0;
            if (edge_r == 2'd2) begin
              state_nxt = rtn_pkg::BK_DIST;
            end else begin
              edge_nxt = edge_r + 2'd1;
            end
          end
          default: ;
        endcase
      end
      rtn_pkg::BK_DIST: begin
        case (step_r)
          5'd0, 5'd1, 5'd2: begin
            mx = rtn_pkg::mulx_t'($signed(d_r[step_r[1:0]]));
            my = rtn_pkg::muly_t'($signed(d_r[step_r[1:0]]));
            mc.issue = 1'b1;
            mc.first = (step_r == 5'd0);
            mc.last  = (step_r == 5'd2);
            mc.dst   = rtn_pkg::DST_DIST;
          end
          5'd4: begin
            state_nxt = rtn_pkg::BK_UPDATE;
            step_nxt  = '0;
          end
          default: ;
        endcase
      end
      rtn_pkg::BK_UPDATE: begin
        step_nxt  = '0;
        state_nxt = it_r.last ? rtn_pkg::BK_EMIT : rtn_pkg::BK_IDLE;
      end
      rtn_pkg::BK_EMIT: begin
        step_nxt = '0;
        if (slot_free) begin
          state_nxt = rtn_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = rtn_pkg::BK_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtn_pkg::BK_IDLE;
      step_r      <= '0;
      edge_r      <= '0;
      hits_r      <= '0;
      best_r      <= '1;
      bp_r        <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      edge_r  <= edge_nxt;
      if (state_r == rtn_pkg::BK_UPDATE && hit) begin
        if (hits_r < CNT_LIMIT) begin
          hits_r <= hits_r + 16'd1;
        end
        if (dist_r < best_r) begin
          best_r <= dist_r;
          bp_r   <= p_r;
        end
      end
      if (state_r == rtn_pkg::BK_EMIT && slot_free) begin
        hits_r      <= '0;
        best_r      <= '1;
        bp_r        <= '{default: '0};
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      it_r      <= q_item;
      cand_r    <= 1'b1;
      oor_r     <= 1'b0;
      any_pos_r <= 1'b0;
      any_neg_r <= 1'b0;
    end
    if (state_r == rtn_pkg::BK_ABS) begin
      un_r       <= num_r[rtn_pkg::QW-1] ? rtn_pkg::QW'(-num_r) : num_r;
      ud_r       <= den_r[rtn_pkg::QW-1] ? rtn_pkg::QW'(-den_r) : den_r;
      sign_bad_r <= (den_r == '0)
                 || ((num_r != '0) && (num_r[rtn_pkg::QW-1] != den_r[rtn_pkg::QW-1]));
    end
    if (state_r == rtn_pkg::BK_RANGE) begin
      rem_r <= un_r >> 16;
      dvd_r <= {un_r[15:0], 16'h0000};
      t_r   <= '0;
      if (reject) begin
        cand_r <= 1'b0;
      end
    end
    if (state_r == rtn_pkg::BK_DIV) begin
      rem_r <= ge ? rtn_pkg::QW'(rem_sh - {1'b0, ud_r}) : rem_sh[rtn_pkg::QW-1:0];
      t_r   <= {t_r[rtn_pkg::T_W-2:0], ge};
      dvd_r <= dvd_r << 1;
    end
    if (state_r == rtn_pkg::BK_POINT && step_r == 5'd4 && oor_r) begin
      cand_r <= 1'b0;
    end
    if (state_r == rtn_pkg::BK_EDGE && step_r == 5'd0) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= rtn_pkg::diff_t'($signed(sv[i])) - rtn_pkg::diff_t'($signed(p_r[i]));
        w_r[i] <= rtn_pkg::diff_t'($signed(ev[i])) - rtn_pkg::diff_t'($signed(p_r[i]));
      end
    end
    if (state_r == rtn_pkg::BK_EMIT && slot_free) begin
      out_word_r.hit_x     <= bp_r[0];
      out_word_r.hit_y     <= bp_r[1];
      out_word_r.hit_z     <= bp_r[2];
      out_word_r.hit_count <= hits_r;
    end
    if (res.en) begin
      case (res.dst)
        rtn_pkg::DST_N0:   n_r[0]  <= res.acc[rtn_pkg::MUL_XW-1:0];
        rtn_pkg::DST_N1:   n_r[1]  <= res.acc[rtn_pkg::MUL_XW-1:0];
        rtn_pkg::DST_N2:   n_r[2]  <= res.acc[rtn_pkg::MUL_XW-1:0];
        rtn_pkg::DST_NUM:  num_r   <= res.acc[rtn_pkg::QW-1:0];
        rtn_pkg::DST_DEN:  den_r   <= res.acc[rtn_pkg::QW-1:0];
        rtn_pkg::DST_P0, rtn_pkg::DST_P1, rtn_pkg::DST_P2: begin
          p_r[pidx] <= psum[15:0];
          d_r[pidx] <= res.acc[32:16];
          if (oor) begin
            oor_r <= 1'b1;
          end
        end
        rtn_pkg::DST_X0:   xc_r[0] <= res.acc[rtn_pkg::MUL_XW-1:0];
        rtn_pkg::DST_X1:   xc_r[1] <= res.acc[rtn_pkg::MUL_XW-1:0];
        rtn_pkg::DST_X2:   xc_r[2] <= res.acc[rtn_pkg::MUL_XW-1:0];
        rtn_pkg::DST_SIGN: begin
          if (res.acc[rtn_pkg::ACC_W-1]) begin
            any_neg_r <= 1'b1;
          end else if (|res.acc) begin
            any_pos_r <= 1'b1;
          end
        end
        rtn_pkg::DST_DIST: dist_r  <= res.acc[rtn_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
